/* sv/ccct_pkg.sv */
// ----------------------------------------------------------------------------
// ccct_pkg
// Shared types and constants of the cluster cone cull test block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccct_pkg;

  // Result codes carried in the outcome field.
  typedef enum logic [2:0] {
    OC_CULLED   = 3'd0,
    OC_MODE_OFF = 3'd1,
    OC_COS_OFF  = 3'd2,
    OC_INSIDE   = 3'd3,
    OC_FACING   = 3'd4
  } outcome_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_POINT_X = 3'd0;
  localparam logic [2:0] REG_POINT_Y = 3'd1;
  localparam logic [2:0] REG_POINT_Z = 3'd2;
  localparam logic [2:0] REG_NORM_X  = 3'd3;
  localparam logic [2:0] REG_NORM_Y  = 3'd4;
  localparam logic [2:0] REG_NORM_Z  = 3'd5;
  localparam logic [2:0] REG_COS     = 3'd6;
  localparam logic [2:0] REG_RADIUS  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // -1.0 in Q2.14; a cosine at or below this turns the test off.
  localparam logic signed [15:0] COS_MINUS_ONE = -16'sd16384;

endpackage

`default_nettype wire

/* sv/ccct_if.sv */
// ----------------------------------------------------------------------------
// ccct_in_if / ccct_out_if
// Valid/ready channels for query beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic               culling_enabled;

  modport source (output valid, eye_x, eye_y, eye_z, culling_enabled, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, culling_enabled, output ready);
endinterface

interface ccct_out_if import ccct_pkg::*;;
  logic     valid;
  logic     ready;
  logic     culled;
  outcome_t outcome;

  modport source (output valid, culled, outcome, input ready);
  modport sink   (input valid, culled, outcome, output ready);
endinterface

`default_nettype wire

/* sv/cluster_cone_cull_test_top.sv */
// ----------------------------------------------------------------------------
// cluster_cone_cull_test_top
// Back-face cone cull test of one cluster against a stream of eye positions.
// ----------------------------------------------------------------------------
// The block takes one query beat per clock (eye position and culling enable)
// while the output side is not stalled, and returns one result beat per
// query, in order. It is a seven-stage pipeline: eye vector, lane products,
// squares and dot sum, vector length and cosine square, split partial
// products of the two squared sides, their sums, and the final compare,
// which also serves as the output register. Every stage holds its beat when
// the next one is full, so a stall at the output fills the pipeline before
// the input is backpressured. The decision is exact: dot < C * |V| is
// decided by comparing squares with the signs taken into account, so no
// square root or rounding is involved. Configuration is written through
// the plain cfg_ port and must only be changed while the pipeline is
// empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cluster_cone_cull_test_top import ccct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ccct_in_if.sink                    in_ch,
  ccct_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers, read directly by several stages. The user must
  // change them only with no beat in flight; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic signed [31:0] point_r [3];
  logic signed [15:0] norm_r  [3];
  logic signed [15:0] cos_r;
  logic        [30:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r[0] <= '0;
      point_r[1] <= '0;
      point_r[2] <= '0;
      norm_r[0]  <= '0;
      norm_r[1]  <= '0;
      norm_r[2]  <= '0;
      cos_r      <= COS_MINUS_ONE;
      radius_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POINT_X: point_r[0] <= cfg_data;
        REG_POINT_Y: point_r[1] <= cfg_data;
        REG_POINT_Z: point_r[2] <= cfg_data;
        REG_NORM_X:  norm_r[0]  <= cfg_data[15:0];
        REG_NORM_Y:  norm_r[1]  <= cfg_data[15:0];
        REG_NORM_Z:  norm_r[2]  <= cfg_data[15:0];
        REG_COS:     cos_r      <= cfg_data[15:0];
        REG_RADIUS:  radius_r   <= cfg_data[30:0];
        default:     ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake. A stage may load when it is empty or when the stage
  // after it loads in the same cycle, so bubbles are squeezed out.
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !s7_v_r || out_ch.ready;
  assign rdy6 = !s6_v_r || rdy7;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_ch.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) s5_v_r <= s4_v_r;
      if (rdy6) s6_v_r <= s5_v_r;
      if (rdy7) s7_v_r <= s6_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: eye vector d = eye - point per lane, and the two early outs
  // (culling off for this visit, cosine at or below -1.0). An early-out code
  // rides along the pipeline and overrides everything at the end.
  // --------------------------------------------------------------------------
  logic signed [31:0] eye [3];
  logic signed [32:0] s1_d_nxt [3];
  logic signed [32:0] s1_d_r   [3];
  logic               s1_skip_nxt, s1_skip_r;
  outcome_t           s1_code_nxt, s1_code_r;

  assign eye[0] = in_ch.eye_x;
  assign eye[1] = in_ch.eye_y;
  assign eye[2] = in_ch.eye_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d_nxt[i] = 33'(eye[i]) - 33'(point_r[i]);
    end
    s1_skip_nxt = 1'b1;
    s1_code_nxt = OC_MODE_OFF;
    if (in_ch.culling_enabled) begin
      if (cos_r <= COS_MINUS_ONE) begin
        s1_code_nxt = OC_COS_OFF;
      end else begin
        s1_skip_nxt = 1'b0;
        s1_code_nxt = OC_FACING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_d_r    <= s1_d_nxt;
      s1_skip_r <= s1_skip_nxt;
      s1_code_r <= s1_code_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: lane magnitudes, lane dot products and the squared radius.
  // --------------------------------------------------------------------------
  logic        [32:0] s2_m_nxt [3];
  logic        [32:0] s2_m_r   [3];
  logic signed [48:0] s2_p_nxt [3];
  logic signed [48:0] s2_p_r   [3];
  logic        [61:0] s2_r2_nxt, s2_r2_r;
  logic               s2_skip_r;
  outcome_t           s2_code_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_m_nxt[i] = s1_d_r[i][32] ? 33'(-s1_d_r[i]) : 33'(s1_d_r[i]);
      s2_p_nxt[i] = 49'(s1_d_r[i]) * 49'(norm_r[i]);
    end
    s2_r2_nxt = 62'(radius_r) * 62'(radius_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_m_r    <= s2_m_nxt;
      s2_p_r    <= s2_p_nxt;
      s2_r2_r   <= s2_r2_nxt;
      s2_skip_r <= s1_skip_r;
      s2_code_r <= s1_code_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: lane squares and the dot sum. A magnitude of 2^32 has a zero
  // low word, so its square is just bit 64.
  // --------------------------------------------------------------------------
  logic        [64:0] s3_sq_nxt [3];
  logic        [64:0] s3_sq_r   [3];
  logic signed [50:0] s3_dot_nxt, s3_dot_r;
  logic        [61:0] s3_r2_r;
  logic               s3_skip_r;
  outcome_t           s3_code_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_sq_nxt[i] = {s2_m_r[i][32], 64'(s2_m_r[i][31:0]) * 64'(s2_m_r[i][31:0])};
    end
    s3_dot_nxt = 51'(s2_p_r[0]) + 51'(s2_p_r[1]) + 51'(s2_p_r[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sq_r   <= s3_sq_nxt;
      s3_dot_r  <= s3_dot_nxt;
      s3_r2_r   <= s2_r2_r;
      s3_skip_r <= s2_skip_r;
      s3_code_r <= s2_code_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared length S, dot magnitude and sign, squared cosine.
  // --------------------------------------------------------------------------
  logic        [65:0] s4_s_nxt, s4_s_r;
  logic        [48:0] s4_md_nxt, s4_md_r;
  logic               s4_dneg_r;
  logic signed [31:0] cos_sq;
  logic        [30:0] s4_c2_r;
  logic        [61:0] s4_r2_r;
  logic               s4_skip_r;
  outcome_t           s4_code_r;

  assign s4_s_nxt  = 66'(s3_sq_r[0]) + 66'(s3_sq_r[1]) + 66'(s3_sq_r[2]);
  assign s4_md_nxt = s3_dot_r[50] ? 49'(-s3_dot_r) : 49'(s3_dot_r);
  assign cos_sq    = 32'(cos_r) * 32'(cos_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_s_r    <= s4_s_nxt;
      s4_md_r   <= s4_md_nxt;
      s4_dneg_r <= s3_dot_r[50];
      s4_c2_r   <= cos_sq[30:0];
      s4_r2_r   <= s3_r2_r;
      s4_skip_r <= s3_skip_r;
      s4_code_r <= s3_code_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: radius test, zero-length test and the partial products of
  // dot^2 (split 17/32) and S * C^2 (split 2/32/32).
  // --------------------------------------------------------------------------
  logic        s5_inside_r, s5_zero_r, s5_dneg_r, s5_skip_r;
  outcome_t    s5_code_r;
  logic [63:0] s5_a0_r;
  logic [48:0] s5_a1_r;
  logic [33:0] s5_a2_r;
  logic [62:0] s5_b0_r, s5_b1_r;
  logic [32:0] s5_b2_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_inside_r <= s4_s_r < 66'(s4_r2_r);
      s5_zero_r   <= s4_s_r == '0;
      s5_a0_r     <= 64'(s4_md_r[31:0]) * 64'(s4_md_r[31:0]);
      s5_a1_r     <= 49'(s4_md_r[48:32]) * 49'(s4_md_r[31:0]);
      s5_a2_r     <= 34'(s4_md_r[48:32]) * 34'(s4_md_r[48:32]);
      s5_b0_r     <= 63'(s4_s_r[31:0]) * 63'(s4_c2_r);
      s5_b1_r     <= 63'(s4_s_r[63:32]) * 63'(s4_c2_r);
      s5_b2_r     <= 33'(s4_s_r[65:64]) * 33'(s4_c2_r);
      s5_dneg_r   <= s4_dneg_r;
      s5_skip_r   <= s4_skip_r;
      s5_code_r   <= s4_code_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine the partial products. The cross term of dot^2 counts
  // twice, hence its shift by 33.
  // --------------------------------------------------------------------------
  logic [97:0] s6_lhs_r, s6_rhs_r;
  logic        s6_inside_r, s6_zero_r, s6_dneg_r, s6_skip_r;
  outcome_t    s6_code_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_lhs_r    <= 98'(s5_a0_r) + (98'(s5_a1_r) << 33) + (98'(s5_a2_r) << 64);
      s6_rhs_r    <= 98'(s5_b0_r) + (98'(s5_b1_r) << 32) + (98'(s5_b2_r) << 64);
      s6_inside_r <= s5_inside_r;
      s6_zero_r   <= s5_zero_r;
      s6_dneg_r   <= s5_dneg_r;
      s6_skip_r   <= s5_skip_r;
      s6_code_r   <= s5_code_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: the decision, registered straight into the result beat.
  // With C >= 0 a negative dot is always below C*|V|; otherwise compare
  // squares. With C < 0 only a negative dot can be below, when dot^2 > C^2*S.
  // --------------------------------------------------------------------------
  logic     s7_culled_nxt, s7_culled_r;
  outcome_t s7_code_nxt, s7_code_r;
  logic     cone_hit;

  always_comb begin
    if (!cos_r[15]) begin
      cone_hit = s6_dneg_r || ((cos_r != '0) && (s6_lhs_r < s6_rhs_r));
    end else begin
      cone_hit = s6_dneg_r && (s6_rhs_r < s6_lhs_r);
    end
    s7_culled_nxt = 1'b0;
    if (s6_skip_r) begin
      s7_code_nxt = s6_code_r;
    end else if (s6_inside_r) begin
      s7_code_nxt = OC_INSIDE;
    end else if (s6_zero_r || !cone_hit) begin
      s7_code_nxt = OC_FACING;
    end else begin
      s7_code_nxt   = OC_CULLED;
      s7_culled_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_culled_r <= s7_culled_nxt;
      s7_code_r   <= s7_code_nxt;
    end
  end

  assign out_ch.valid   = s7_v_r;
  assign out_ch.culled  = s7_culled_r;
  assign out_ch.outcome = s7_code_r;

`ifndef SYNTHESIS
  // The culled flag and the outcome code agree on every delivered beat.
  a_culled_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.culled == (out_ch.outcome == OC_CULLED)))
    else $error("culled flag disagrees with outcome");

  // An empty first stage never backpressures the input.
  a_in_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ch.ready)
    else $error("input stalled with empty first stage");

  // A beat held in the middle of the pipeline is not dropped.
  a_mid_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !rdy5) |=> s4_v_r)
    else $error("stalled beat lost in stage 4");

  // An early-out code reaches the result unchanged.
  a_skip_code : assert property (@(posedge clk) disable iff (!rst_n)
    (s6_v_r && s6_skip_r && rdy7) |=> (s7_v_r && s7_code_r == $past(s6_code_r)))
    else $error("early-out code altered at final stage");
`endif

endmodule

`default_nettype wire

/* sim/tb_cluster_cone_cull_test_top.sv */
// ----------------------------------------------------------------------------
// tb_cluster_cone_cull_test_top
// Self-checking testbench of the cluster back-face cone cull test.
// ----------------------------------------------------------------------------
// Query beats go in through the input channel. The testbench keeps its own
// copy of the eight configuration registers and computes the expected
// verdict of every accepted query with exact 128-bit integer arithmetic.
// Each result beat is then compared, field by field, against the oldest
// pending verdict. The run starts with the reset values and a short directed
// list. Random traffic follows under several idling patterns, with the
// configuration redrawn every fifty queries once drained. It ends with a long
// output stall that backs the pipeline up into the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cluster_cone_cull_test_top;
  import ccct_pkg::*;

  // Pipeline depth from accepted query to result beat, unstalled.
  localparam int PIPE_LATENCY = 7;
  // Generous cycle budget for the watchdog.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic               culling_enabled;
  } eye_query_t;

  typedef struct {
    logic     culled;
    outcome_t outcome;
  } cull_result_t;

  // These are the raw words that go onto cfg_data. Upper bits beyond a
  // register's width may carry junk, which the block must mask off.
  typedef struct {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
    logic [31:0] cosine;
    logic [31:0] radius;
  } cfg_words_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccct_in_if  in_ch ();
  ccct_out_if out_ch ();

  cluster_cone_cull_test_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // This is the testbench's copy of the configuration, kept at register widths.
  logic signed [31:0] cur_point  [3];
  logic signed [15:0] cur_normal [3];
  logic signed [15:0] cur_cosine;
  logic        [30:0] cur_radius;

  cull_result_t pending_verdicts [$];

  int src_idle_pct = 0;  // chance per cycle that the sender holds back
  int snk_idle_pct = 0;  // chance per cycle that the receiver stalls
  int hold_req     = 0;  // a test asks for a long receiver stall here
  int hold_left    = 0;  // the stall process counts the stall down here
  int cycle_count  = 0;
  int fail_count   = 0;
  int result_count = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void track_cfg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_POINT_X: cur_point[0]  = data;
      REG_POINT_Y: cur_point[1]  = data;
      REG_POINT_Z: cur_point[2]  = data;
      REG_NORM_X:  cur_normal[0] = data[15:0];
      REG_NORM_Y:  cur_normal[1] = data[15:0];
      REG_NORM_Z:  cur_normal[2] = data[15:0];
      REG_COS:     cur_cosine    = data[15:0];
      REG_RADIUS:  cur_radius    = data[30:0];
      default: ;
    endcase
  endfunction

  // This computes the verdict for one query. The question dot < C * |V| is
  // settled by comparing squares, with the signs handled separately, so
  // everything stays in exact integers.
  // Worst case magnitudes are about 2^98, so 128 signed bits are plenty.
  function automatic cull_result_t predict_cull(eye_query_t q);
    wide_t dx, dy, dz, sq_len, dot, rad, rad_sq, cosv, dot_sq, len_cos_sq;
    cull_result_t r;
    r.culled = 1'b0;
    if (!q.culling_enabled) begin
      r.outcome = OC_MODE_OFF;
      return r;
    end
    if (cur_cosine <= COS_MINUS_ONE) begin
      r.outcome = OC_COS_OFF;
      return r;
    end
    dx = q.eye_x;
    dy = q.eye_y;
    dz = q.eye_z;
    dx = dx - cur_point[0];
    dy = dy - cur_point[1];
    dz = dz - cur_point[2];
    sq_len = dx * dx + dy * dy + dz * dz;
    dot    = dx * cur_normal[0] + dy * cur_normal[1] + dz * cur_normal[2];
    rad    = cur_radius;
    rad_sq = rad * rad;
    if (sq_len < rad_sq) begin
      r.outcome = OC_INSIDE;
      return r;
    end
    // A zero-length eye vector has no direction, so it is never culled.
    if (sq_len == 0) begin
      r.outcome = OC_FACING;
      return r;
    end
    cosv       = cur_cosine;
    dot_sq     = dot * dot;
    len_cos_sq = sq_len * cosv * cosv;
    if (cosv >= 0)
      r.culled = (dot < 0) || ((cosv > 0) && (dot_sq < len_cos_sq));
    else
      r.culled = (dot < 0) && (len_cos_sq < dot_sq);
    r.outcome = r.culled ? OC_CULLED : OC_FACING;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic eye_query_t query(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z, logic en);
    eye_query_t q;
    q.eye_x = x;
    q.eye_y = y;
    q.eye_z = z;
    q.culling_enabled = en;
    return q;
  endfunction

  function automatic cfg_words_t make_cfg(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [31:0] nx,
                                          logic [31:0] ny, logic [31:0] nz,
                                          logic [31:0] cosine, logic [31:0] rad);
    cfg_words_t c;
    c.point_x  = px;
    c.point_y  = py;
    c.point_z  = pz;
    c.normal_x = nx;
    c.normal_y = ny;
    c.normal_z = nz;
    c.cosine   = cosine;
    c.radius   = rad;
    return c;
  endfunction

  function automatic logic [31:0] rand_point_word();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3: ;
      default: v = v >>> 12;
    endcase
    return v;
  endfunction

  // Normals are mostly in range with junk in the unused upper bits. Now and
  // then one is fully random, which the block must still use as given.
  function automatic logic [31:0] rand_normal_word();
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(7) == 0)
      return junk;
    return {junk[31:16], 16'($urandom_range(32768) - 16384)};
  endfunction

  function automatic cfg_words_t rand_config();
    cfg_words_t c;
    logic [31:0] junk;
    logic [15:0] cos16;
    int kr;
    junk = $urandom;
    c.point_x  = rand_point_word();
    c.point_y  = rand_point_word();
    c.point_z  = rand_point_word();
    c.normal_x = rand_normal_word();
    c.normal_y = rand_normal_word();
    c.normal_z = rand_normal_word();
    case ($urandom_range(11))
      0: cos16 = COS_MINUS_ONE;
      1: cos16 = 16'h8000;
      2: cos16 = 16'h7FFF;
      3: cos16 = 16'sd16384;
      4: cos16 = 16'h0000;
      default: cos16 = 16'($urandom_range(32767) - 16383);
    endcase
    c.cosine = {junk[31:16], cos16};
    case ($urandom_range(9))
      0: c.radius = {junk[31], 31'd0};
      1: c.radius = 32'hFFFF_FFFF;
      2: c.radius = $urandom;
      default: begin
        kr = $urandom_range(26, 8);
        c.radius = {junk[31], 31'($urandom_range(0, 32'd1 << kr))};
      end
    endcase
    return c;
  endfunction

  // Most eyes lie at a random scale around the cluster point, so the
  // inside, facing and culled outcomes all turn up. A few are drawn from
  // the whole coordinate range.
  function automatic eye_query_t rand_query();
    logic signed [31:0] dl [3];
    eye_query_t q;
    int k;
    k = $urandom_range(31, 4);
    for (int i = 0; i < 3; i++) begin
      dl[i] = $urandom;
      dl[i] = dl[i] >>> (31 - k);
    end
    if ($urandom_range(9) == 0)
      q = query($urandom, $urandom, $urandom, 1'b1);
    else
      q = query(cur_point[0] + dl[0], cur_point[1] + dl[1], cur_point[2] + dl[2], 1'b1);
    q.culling_enabled = ($urandom_range(15) != 0);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // This offers one query beat, after a random gap, and holds it until it is
  // accepted. The beat stays valid on return so that back-to-back calls
  // stream without a bubble; end_burst drops it.
  task automatic send_query(eye_query_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.eye_x           <= q.eye_x;
    in_ch.eye_y           <= q.eye_y;
    in_ch.eye_z           <= q.eye_z;
    in_ch.culling_enabled <= q.culling_enabled;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_verdicts.push_back(predict_cull(q));
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  // This waits for the last expected beat, then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    track_cfg_write(idx, data);
  endtask

  // Registers may only change while the pipeline is empty, so this
  // quiesces the input, drains, and then writes all eight registers.
  task automatic load_config(cfg_words_t c);
    end_burst();
    wait_drained();
    cfg_put(REG_POINT_X, c.point_x);
    cfg_put(REG_POINT_Y, c.point_y);
    cfg_put(REG_POINT_Z, c.point_z);
    cfg_put(REG_NORM_X,  c.normal_x);
    cfg_put(REG_NORM_Y,  c.normal_y);
    cfg_put(REG_NORM_Z,  c.normal_z);
    cfg_put(REG_COS,     c.cosine);
    cfg_put(REG_RADIUS,  c.radius);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the cosine reads -1.0, so every enabled query skips the
  // test and every disabled one reports mode off.
  task automatic test_reset_values();
    send_query(query(32'sd65536, -32'sd1, 32'sh7FFF_FFFF, 1'b1));
    send_query(query(32'sd0, 32'sd0, 32'sd0, 1'b1));
    send_query(query(32'sh8000_0000, 32'sd3, 32'sd0, 1'b0));
  endtask

  task automatic test_directed();
    // The normal is +z with a cosine of 0, meaning cull anything seen from
    // behind.
    load_config(make_cfg(0, 0, 0, 0, 0, 16384, 0, 0));
    send_query(query(0, 0, 1, 1'b0));                 // culling switched off
    send_query(query(0, 0, 0, 1'b1));                 // zero-length eye vector
    send_query(query(0, 0, 65536, 1'b1));             // seen from the front
    send_query(query(0, 0, -65536, 1'b1));            // seen from behind
    send_query(query(65536, 0, 0, 1'b1));             // edge-on, cosine 0
    send_query(query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
    send_query(query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));

    // The point sits at the coordinate extremes, the cosine is +1.0 and the
    // guard radius is at its maximum.
    load_config(make_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         16384, 32'hFFFF_C000, 16384, 16384, 32'h7FFF_FFFF));
    send_query(query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
    send_query(query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
    // An eye exactly on the guard sphere is outside; one unit closer is inside.
    send_query(query(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
    send_query(query(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));

    // A negative cosine of -0.5 only culls eyes well behind the cluster.
    load_config(make_cfg(0, 0, 0, 0, 0, 16384, 32'hFFFF_E000, 0));
    send_query(query(0, 0, -65536, 1'b1));
    send_query(query(65536, 0, -65536, 1'b1));
    send_query(query(131072, 0, -65536, 1'b1));

    // A cosine of exactly -1.0, and the code below it, both skip the test.
    load_config(make_cfg(0, 0, 0, 0, 0, 16384, 32'h1234_C000, 0));
    send_query(query(0, 0, -65536, 1'b1));
    load_config(make_cfg(0, 0, 0, 0, 0, 16384, 32'hFFFF_8000, 0));
    send_query(query(0, 0, -65536, 1'b1));

    // Normal and cosine outside the unit range are used exactly as written.
    load_config(make_cfg(0, 0, 0, 32'hABCD_8000, 32'h0000_7FFF, 32'hFFFF_8000,
                         32'h5555_7FFF, 32'h8000_0000));
    send_query(query(65536, 65536, 65536, 1'b1));
    send_query(query(-65536, -1, 7, 1'b1));

    // At cosine +1.0 along the normal the two sides are equal, which does
    // not cull. The slightest tilt does.
    load_config(make_cfg(0, 0, 0, 16384, 0, 0, 16384, 0));
    send_query(query(65536, 0, 0, 1'b1));
    send_query(query(65536, 1, 0, 1'b1));
  endtask

  // This runs random traffic under one idling pattern. The configuration is
  // redrawn every fifty queries, with the pipeline drained in between. The
  // last beat is dropped by the configuration load that follows.
  task automatic test_random_traffic(int src_pct, int snk_pct, int n_items);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0)
        load_config(rand_config());
      send_query(rand_query());
    end
  endtask

  // The receiver stops for a long stretch while queries keep coming. The
  // pipeline fills and the input channel must push back. Afterwards the
  // sender waits for every result before it sends a final burst.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_config(rand_config());
    hold_req = 60;
    for (int i = 0; i < 40; i++)
      send_query(rand_query());
    end_burst();
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_query(rand_query());
    end_burst();
  endtask

  // --------------------------------------------------------------------------
  // Receiver, long-stall counter and result checker
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic void note_failure(string what, int expected_val, int actual_val);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("ERROR: result %0d %s: expected %0d, got %0d",
               result_count, what, expected_val, actual_val);
  endfunction

  always @(posedge clk) begin
    cull_result_t exp_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        note_failure("arrived with nothing pending, outcome", -1, out_ch.outcome);
      end else begin
        exp_r = pending_verdicts.pop_front();
        if (out_ch.culled !== exp_r.culled)
          note_failure("culled", exp_r.culled, out_ch.culled);
        if (out_ch.outcome !== exp_r.outcome)
          note_failure("outcome", exp_r.outcome, out_ch.outcome);
      end
      result_count++;
    end
  end

  // This is the watchdog, which bounds the run in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending",
               cycle_count, pending_verdicts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_POINT_X;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.eye_x           = '0;
    in_ch.eye_y           = '0;
    in_ch.eye_z           = '0;
    in_ch.culling_enabled = 1'b0;
    out_ch.ready          = 1'b0;
    cur_point[0]  = '0;
    cur_point[1]  = '0;
    cur_point[2]  = '0;
    cur_normal[0] = '0;
    cur_normal[1] = '0;
    cur_normal[2] = '0;
    cur_cosine    = COS_MINUS_ONE;
    cur_radius    = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_random_traffic(0, 0, 350);
    test_random_traffic(75, 0, 350);
    test_random_traffic(0, 75, 350);
    test_random_traffic(15, 15, 350);
    test_backpressure();

    wait_drained();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
